// ===== src/sird_pkg.sv =====
// ----------------------------------------------------------------------------
// sird_pkg: shared types and constants for the radix digit unit
// Character codes, configuration register indexes, division step size and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sird_pkg;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Smallest usable radix
  localparam int unsigned MIN_RADIX = 2;

  // Register widths
  localparam int unsigned RADIX_W   = 5;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned REM_W     = 5;

  // Dividend bits retired per division cycle
  localparam int unsigned STEP_BITS = 8;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } cfg_idx_t;

  // Output character source
  typedef enum logic [1:0] {
    SEL_BAD,
    SEL_ZERO,
    SEL_SIGN,
    SEL_DIGIT
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;       // capture input value
    logic     div_step;   // run one division chunk
    logic     div_first;  // first chunk of a digit: clear remainder
    logic     wr_en;      // write finished digit into the store
    logic     rd_en;      // registered read of the digit store
    logic     out_load;   // load the output register
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ok;         // alphabet valid (captured with the value)
    logic negative;   // captured value is negative
    logic q_zero;     // working quotient is zero
    logic slot_free;  // output register can take a character
  } sts_t;

endpackage

// ===== src/sird_ifs.sv =====
// ----------------------------------------------------------------------------
// sird_ifs: valid/ready channel interfaces of the radix digit unit
// Input channel carries the signed value, output channel one character.
// ----------------------------------------------------------------------------
interface sird_in_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sird_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  logic       bad_alphabet;

  modport source (output valid, output text_byte, output last_byte,
                  output bad_alphabet, input ready);
  modport sink   (input valid, input text_byte, input last_byte,
                  input bad_alphabet, output ready);
endinterface

// ===== src/sird_dp.sv =====
// ----------------------------------------------------------------------------
// sird_dp: datapath of the radix digit unit
// Configuration registers, alphabet check, chunked divider, digit store and
// the output register.
// ----------------------------------------------------------------------------
module sird_dp #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [sird_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [sird_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic [VALUE_BITS-1:0]                   in_value,
  input  sird_pkg::cmd_t                          cmd,
  input  logic [$clog2(MAX_DIGITS)-1:0]           addr,
  output sird_pkg::sts_t                          sts,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [7:0]                              out_text,
  output logic                                    out_last,
  output logic                                    out_bad
);
  import sird_pkg::*;

  localparam int unsigned CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned DIV_W  = CHUNKS * STEP_BITS;
  localparam int unsigned NSYM   = 16;

  logic [RADIX_W-1:0]    radix;
  logic [CFG_DATA_W-1:0] alpha_lo;
  logic [CFG_DATA_W-1:0] alpha_hi;
  logic [2*CFG_DATA_W-1:0] alpha;
  logic                  ok;
  logic                  ok_q;
  logic                  neg_q;
  logic [DIV_W-1:0]      quo;
  logic [REM_W-1:0]      rem;
  logic [REM_W-1:0]      rem_next;
  logic [STEP_BITS-1:0]  qbits;
  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    store [MAX_DIGITS];
  logic [DIGIT_W-1:0]    rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= '0;
      alpha_lo <= '0;
      alpha_hi <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_RADIX:    radix    <= cfg_wdata[RADIX_W-1:0];
        REG_ALPHA_LO: alpha_lo <= cfg_wdata;
        REG_ALPHA_HI: alpha_hi <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign alpha = {alpha_hi, alpha_lo};

  // Alphabet check: radix range, no sign characters, no repeated symbols
  always_comb begin
    logic [7:0] si;
    logic [7:0] sj;
    ok = (radix >= RADIX_W'(MIN_RADIX)) && (radix <= RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NSYM; i++) begin
      si = alpha[i*8 +: 8];
      if ((RADIX_W'(i) < radix) && ((si == CH_MINUS) || (si == CH_PLUS)))
        ok = 1'b0;
      for (int j = i + 1; j < NSYM; j++) begin
        sj = alpha[j*8 +: 8];
        if ((RADIX_W'(j) < radix) && (si == sj))
          ok = 1'b0;
      end
    end
  end

  // Magnitude of the incoming value
  assign mag = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;

  // One chunk of restoring division by the radix
  always_comb begin
    logic [REM_W-1:0]     r;
    logic [REM_W-1:0]     t;
    logic [STEP_BITS-1:0] chunk;
    r     = cmd.div_first ? '0 : rem;
    chunk = quo[DIV_W-1 -: STEP_BITS];
    qbits = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      t = {r[REM_W-2:0], chunk[k]};
      if (t >= radix) begin
        qbits[k] = 1'b1;
        r        = t - radix;
      end else begin
        r = t;
      end
    end
    rem_next = r;
  end

  // Working quotient, remainder and captured flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo   <= DIV_W'(mag);
      neg_q <= in_value[VALUE_BITS-1];
      ok_q  <= ok;
    end else if (cmd.div_step) begin
      quo <= (quo << STEP_BITS) | DIV_W'(qbits);
      rem <= rem_next;
    end
  end

  // Digit store, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (cmd.wr_en)
      store[addr] <= rem_next[DIGIT_W-1:0];
    if (cmd.rd_en)
      rd_data <= store[addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last <= cmd.out_last;
      out_bad  <= (cmd.out_sel == SEL_BAD);
      case (cmd.out_sel)
        SEL_BAD:   out_text <= '0;
        SEL_ZERO:  out_text <= alpha[7:0];
        SEL_SIGN:  out_text <= CH_MINUS;
        SEL_DIGIT: out_text <= alpha[{rd_data, 3'b000} +: 8];
        default:   out_text <= '0;
      endcase
    end
  end

  // Status to the controller
  assign sts.ok        = ok_q;
  assign sts.negative  = neg_q;
  assign sts.q_zero    = (quo == '0);
  assign sts.slot_free = !out_valid || out_ready;

endmodule

// ===== src/sird_ctrl.sv =====
// ----------------------------------------------------------------------------
// sird_ctrl: controller of the radix digit unit
// Sequences capture, per-digit division chunks, store readback and the
// emission of sign and digits, or of one zero or bad-alphabet character, into the output register.
// ----------------------------------------------------------------------------
module sird_ctrl #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sird_pkg::sts_t                sts,
  output sird_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_DIGITS)-1:0] addr
);
  import sird_pkg::*;

  localparam int unsigned CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned STEP_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_PREP,
    S_SIGN,
    S_EMIT,
    S_ONE
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic              digits_done;

  assign cnt_m1 = cnt - CNT_W'(1);
  assign cnt_m2 = cnt - CNT_W'(2);
  assign digits_done = (cnt != '0) && (sts.q_zero || (cnt == CNT_W'(MAX_DIGITS)));

  // Next state and commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    addr       = cnt[ADDR_W-1:0];
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        step_next = '0;
        cnt_next  = '0;
        if (!sts.ok || sts.q_zero)
          state_next = S_ONE;
        else
          state_next = S_DIV;
      end
      S_DIV: begin
        if ((step == '0) && digits_done) begin
          state_next = S_PREP;
        end else begin
          cmd.div_step  = 1'b1;
          cmd.div_first = (step == '0);
          if (step == STEP_W'(CHUNKS - 1)) begin
            cmd.wr_en = 1'b1;
            step_next = '0;
            cnt_next  = cnt + CNT_W'(1);
          end else begin
            step_next = step + STEP_W'(1);
          end
        end
      end
      S_PREP: begin
        cmd.rd_en  = 1'b1;
        addr       = cnt_m1[ADDR_W-1:0];
        state_next = sts.negative ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_SIGN;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        addr = cnt_m2[ADDR_W-1:0];
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DIGIT;
          cmd.out_last = (cnt == CNT_W'(1));
          cmd.rd_en    = (cnt >= CNT_W'(2));
          cnt_next     = cnt_m1;
          if (cnt == CNT_W'(1))
            state_next = S_IDLE;
        end
      end
      S_ONE: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sts.ok ? SEL_ZERO : SEL_BAD;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== src/signed_int_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_unit: signed integer to text in a set radix
//
// in_ch takes one signed value per transaction; out_ch gives its text one
// character per transaction, most significant digit first, with a leading
// '-' for negative values and last_byte on the final character. A bad
// alphabet (radix outside 2..MAX_RADIX, a repeated symbol, or '+'/'-' among
// the symbols) gives a single transaction with bad_alphabet set and no text.
// The config port writes radix (index 0) and the two alphabet words (1, 2).
// Digits come from a divider retiring 8 dividend bits a cycle, with
// ceil(VALUE_BITS/8) chunks per digit; the digits are then read back from
// the digit store one per cycle while the receiver is ready. A zero value
// gives the single character alphabet[0]. One item is in flight at a time;
// in_ch.ready is high only while no item is being worked on. The output
// register lets a new item be taken while the last character still waits.
// A receiver stall freezes emission without loss. Reset clears the
// configuration registers to zero (an invalid alphabet) and empties the
// output register.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_unit #(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned MAX_DIGITS = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sird_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sird_pkg::CFG_DATA_W-1:0] cfg_wdata,
  sird_in_if.sink                         in_ch,
  sird_out_if.source                      out_ch
);
  import sird_pkg::*;

  cmd_t                          cmd;
  sts_t                          sts;
  logic [$clog2(MAX_DIGITS)-1:0] addr;

  // Control
  sird_ctrl #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Datapath
  sird_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIX  (MAX_RADIX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_value  (VALUE_BITS'(in_ch.value)),
    .cmd       (cmd),
    .addr      (addr),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_text  (out_ch.text_byte),
    .out_last  (out_ch.last_byte),
    .out_bad   (out_ch.bad_alphabet)
  );

  // A bad-alphabet transaction is a single, empty character
  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_alphabet |-> out_ch.last_byte && (out_ch.text_byte == 8'h00))
    else $error("bad alphabet result not a single empty transaction");

  // Only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  // Never overwrite a character that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.out_load && out_ch.valid && !out_ch.ready))
    else $error("output register overwritten while stalled");

  // Digit writes and reads never happen in the same cycle
  a_store_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en))
    else $error("digit store written and read together");

endmodule
